>>> hdl/smpq_pkg.sv
// package for the sorted min priority queue: request and result types,
// operation codes and the per-cell control group. no dependencies.
`default_nettype none

package smpq_pkg;

    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int TAG_W   = 16;
    localparam int KEY_W   = MONTH_W + DAY_W;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_PEEK  = 2'd2,
        FUNC_SPARE = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [MONTH_W-1:0] key_month;
        logic [DAY_W-1:0]   key_day;
        logic [TAG_W-1:0]   entry_tag;
    } in_t;

    typedef struct packed {
        logic               head_valid;
        logic [TAG_W-1:0]   head_tag;
        logic [MONTH_W-1:0] head_month;
        logic [DAY_W-1:0]   head_day;
        logic [COUNT_W-1:0] entry_count;
        logic               op_rejected;
    } out_t;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    // control sent to every cell in the row each cycle
    typedef struct packed {
        logic push;      // accepted push that fits
        logic pop;       // accepted pop on a non-empty queue
        logic occupied;  // this cell holds a live entry
        logic at_tail;   // first free cell
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/smpq_cell.sv
// one slot of the sorted queue row: holds an entry, compares it with the
// incoming key and shifts toward either neighbor. depends on smpq_pkg.
`default_nettype none

module smpq_cell
    import smpq_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     new_entry,
    input  wire logic       left_gt,
    input  wire entry_t     left_entry,
    input  wire entry_t     right_entry,
    output logic            gt,
    output entry_t          entry,
    output entry_t          entry_next
);

    entry_t entry_reg;

    // strictly larger key moves back, so equal keys keep arrival order
    assign gt = ctrl.occupied &&
                ({entry_reg.month, entry_reg.day} > {new_entry.month, new_entry.day});

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            if (left_gt)
                entry_next = left_entry;
            else if (gt || ctrl.at_tail)
                entry_next = new_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

>>> hdl/sorted_min_priority_queue_unit.sv
// top level of the sorted min priority queue: a row of smpq_cell slots,
// the fill count and the result register. depends on smpq_pkg, smpq_cell.
//
// usage:
//   requests arrive on in_valid/in_ready/in_data (func, key_month, key_day,
//   entry_tag). func push inserts in key order (month, then day; equal keys
//   leave in arrival order), pop drops the head, peek and code 3 only report.
//   every request yields exactly one result on out_valid/out_ready/out_data:
//   the head after the request, the entry count and a reject flag (push to
//   a full queue, pop on an empty one; neither changes the queue).
// timing:
//   out_valid rises in the cycle after acceptance. one request per cycle
//   is taken as long as the result register is empty or is being drained
//   in the same cycle; the whole row of cells shifts together, so
//   the result register is the only limit.
// reset:
//   rst_n clears the fill count and the result valid; slot contents are
//   left as they are and only slots below the count are ever read.
// stall:
//   while out_ready is low a pending result holds and in_ready drops, so no
//   request is taken until the result is delivered.
`default_nettype none

module sorted_min_priority_queue_unit
    import smpq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    out_t          out_data_reg;
    out_t          out_data_next;

    logic          accept;
    logic          is_push;
    logic          is_pop;
    logic          full;
    logic          empty;
    logic          do_push;
    logic          do_pop;
    logic          rejected;
    entry_t        new_entry;

    cell_ctrl_t    ctrl     [CAPACITY];
    logic          gt       [CAPACITY];
    entry_t        slot     [CAPACITY];
    entry_t        slot_nxt [CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_push  = (in_data.func == FUNC_PUSH);
    assign is_pop   = (in_data.func == FUNC_POP);
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign do_push  = accept && is_push && !full;
    assign do_pop   = accept && is_pop && !empty;
    assign rejected = (is_push && full) || (is_pop && empty);

    assign new_entry.month = in_data.key_month;
    assign new_entry.day   = in_data.key_day;
    assign new_entry.tag   = in_data.entry_tag;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ctrl[i].push     = do_push;
            ctrl[i].pop      = do_pop;
            ctrl[i].occupied = (CW'(i) < count_reg);
            ctrl[i].at_tail  = (CW'(i) == count_reg);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic   l_gt;
        entry_t l_entry;
        entry_t r_entry;

        if (g == 0)
        begin : g_first
            assign l_gt    = 1'b0;
            assign l_entry = new_entry;
        end
        else
        begin : g_mid
            assign l_gt    = gt[g-1];
            assign l_entry = slot[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign r_entry = slot[g];
        end
        else
        begin : g_inner
            assign r_entry = slot[g+1];
        end

        smpq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl[g]),
            .new_entry   (new_entry),
            .left_gt     (l_gt),
            .left_entry  (l_entry),
            .right_entry (r_entry),
            .gt          (gt[g]),
            .entry       (slot[g]),
            .entry_next  (slot_nxt[g])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
            count_next = count_reg + CW'(1);
        else if (do_pop)
            count_next = count_reg - CW'(1);
    end

    always_comb
    begin
        out_data_next             = '0;
        out_data_next.entry_count = COUNT_W'(count_next);
        out_data_next.op_rejected = rejected;
        if (count_next != '0)
        begin
            out_data_next.head_valid = 1'b1;
            out_data_next.head_tag   = slot_nxt[0].tag;
            out_data_next.head_month = slot_nxt[0].month;
            out_data_next.head_day   = slot_nxt[0].day;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted request gave no result");

    a_reject_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rejected) |=> $stable(count_reg))
        else $error("rejected request changed the fill count");

    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.head_valid == (out_data.entry_count != '0)))
        else $error("head valid disagrees with entry count");
`endif

endmodule

`default_nettype wire
